FILE: sv/ghe_pkg.sv
package ghe_pkg;

    localparam int BIN_W   = 24;
    localparam int DIM_W   = 13;
    localparam int PIX_W   = 8;
    localparam int CMD_W   = 2;
    localparam int TOT_W   = 26;
    localparam int NUM_W   = 32;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_CUM   = 2'd2,
        CMD_MAP   = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    // Handshake between sequencer and divider
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [TOT_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quo;
    } div_rsp_t;

endpackage

FILE: sv/ghe_if.sv
interface ghe_in_if;
    logic                      valid;
    logic                      ready;
    logic [ghe_pkg::CMD_W-1:0] cmd;
    logic [ghe_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, cmd, pixel_value, input ready);
    modport sink (input valid, cmd, pixel_value, output ready);
endinterface

interface ghe_out_if;
    logic                      valid;
    logic                      ready;
    logic [ghe_pkg::PIX_W-1:0] equalised_pixel;

    modport source (output valid, equalised_pixel, input ready);
    modport sink (input valid, equalised_pixel, output ready);
endinterface

FILE: sv/ghe_div.sv
// Restoring divider, one quotient bit per cycle, saturating at PIX_MAX.
module ghe_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ghe_pkg::div_req_t req,
    output ghe_pkg::div_rsp_t rsp
);
    localparam int CNT_W = $clog2(ghe_pkg::NUM_W + 1);

    logic [ghe_pkg::NUM_W-1:0] num_reg;
    logic [ghe_pkg::TOT_W:0]   rem_reg;
    logic [ghe_pkg::TOT_W-1:0] den_reg;
    logic [ghe_pkg::NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [ghe_pkg::TOT_W+1:0] shifted;
    logic [ghe_pkg::TOT_W+1:0] diff;

    assign shifted = {rem_reg, num_reg[ghe_pkg::NUM_W-1]};
    assign diff    = shifted - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ghe_pkg::NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in one numerator bit, subtract when it fits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[ghe_pkg::NUM_W-2:0], 1'b0};
            if (!diff[ghe_pkg::TOT_W+1])
            begin
                rem_reg <= diff[ghe_pkg::TOT_W:0];
                quo_reg <= {quo_reg[ghe_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[ghe_pkg::TOT_W:0];
                quo_reg <= {quo_reg[ghe_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (quo_reg > ghe_pkg::NUM_W'(ghe_pkg::PIX_MAX))
                      ? ghe_pkg::PIX_MAX : quo_reg[ghe_pkg::PIX_W-1:0];
endmodule

FILE: sv/ghe_ctrl.sv
// Sequencer around the bin memory: clear, count, cumulative and map.
module ghe_ctrl #(
    parameter int NUM_BINS = 256,
    parameter int MAX_DIM  = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ghe_in_if.sink                     in_ch,
    ghe_out_if.source                  out_ch,
    input  logic [ghe_pkg::DIM_W-1:0]  width_cfg,
    input  logic [ghe_pkg::DIM_W-1:0]  height_cfg,
    output ghe_pkg::div_req_t          div_req,
    input  ghe_pkg::div_rsp_t          div_rsp
);
    localparam int AW = $clog2(NUM_BINS);

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_COUNT_RD, S_COUNT_WR, S_CUM, S_MAP_RD, S_MAP_MUL, S_MAP_DIV
    } state_t;

    state_t                    state_reg;
    logic [AW-1:0]             addr_reg;
    logic [ghe_pkg::BIN_W-1:0] prev_reg;
    logic [ghe_pkg::NUM_W-1:0] prod_reg;
    logic [ghe_pkg::TOT_W-1:0] total_reg;
    logic                      out_valid_reg;
    logic [ghe_pkg::PIX_W-1:0] out_pix_reg;

    // Bin memory, registered read data
    logic [ghe_pkg::BIN_W-1:0] mem [NUM_BINS];
    logic [ghe_pkg::BIN_W-1:0] rd_data_reg;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [ghe_pkg::BIN_W-1:0] wr_data;

    logic [ghe_pkg::DIM_W-1:0] w_eff;
    logic [ghe_pkg::DIM_W-1:0] h_eff;
    logic [ghe_pkg::BIN_W:0]   sum;
    logic [ghe_pkg::BIN_W-1:0] sat_sum;
    logic [ghe_pkg::BIN_W:0]   inc;

    function automatic logic [ghe_pkg::DIM_W-1:0] eff_dim(input logic [ghe_pkg::DIM_W-1:0] d);
        logic [ghe_pkg::DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = ghe_pkg::DIM_W'(1);
        else if (d > ghe_pkg::DIM_W'(MAX_DIM))
            r = ghe_pkg::DIM_W'(MAX_DIM);
        return r;
    endfunction

    assign w_eff   = eff_dim(width_cfg);
    assign h_eff   = eff_dim(height_cfg);
    assign sum     = {1'b0, rd_data_reg} + {1'b0, prev_reg};
    assign sat_sum = sum[ghe_pkg::BIN_W] ? ghe_pkg::BIN_MAX : sum[ghe_pkg::BIN_W-1:0];
    assign inc     = {1'b0, rd_data_reg} + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Read address and write-back
    always_comb
    begin
        rd_addr = addr_reg;
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = in_ch.pixel_value[AW-1:0];
                if (in_ch.valid && in_ch.cmd == ghe_pkg::CMD_CUM)
                    rd_addr = '0;
            end
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_COUNT_WR:
            begin
                wr_en   = 1'b1;
                wr_data = inc[ghe_pkg::BIN_W] ? ghe_pkg::BIN_MAX : inc[ghe_pkg::BIN_W-1:0];
            end
            S_CUM:
            begin
                // rd_data_reg holds bin addr_reg; write running sum back
                wr_en   = 1'b1;
                wr_data = sat_sum;
                rd_addr = addr_reg + 1'b1;
            end
            default:
            begin
                rd_addr = addr_reg;
            end
        endcase
    end

    assign in_ch.ready     = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.equalised_pixel = out_pix_reg;
    assign div_req.start   = (state_reg == S_MAP_MUL);
    assign div_req.num     = prod_reg;
    assign div_req.den     = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            prod_reg      <= '0;
            total_reg     <= '0;
            out_pix_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        case (in_ch.cmd)
                            ghe_pkg::CMD_CLEAR:
                            begin
                                addr_reg  <= '0;
                                state_reg <= S_CLEAR;
                            end
                            ghe_pkg::CMD_COUNT:
                            begin
                                addr_reg  <= in_ch.pixel_value[AW-1:0];
                                state_reg <= S_COUNT_RD;
                            end
                            ghe_pkg::CMD_CUM:
                            begin
                                addr_reg  <= '0;
                                prev_reg  <= '0;
                                state_reg <= S_CUM;
                            end
                            default:
                            begin
                                addr_reg  <= in_ch.pixel_value[AW-1:0];
                                state_reg <= S_MAP_RD;
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == AW'(NUM_BINS - 1))
                        state_reg <= S_IDLE;
                end
                S_COUNT_RD: state_reg <= S_COUNT_WR;
                S_COUNT_WR: state_reg <= S_IDLE;
                S_CUM:
                begin
                    prev_reg <= sat_sum;
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == AW'(NUM_BINS - 1))
                        state_reg <= S_IDLE;
                end
                S_MAP_RD:
                begin
                    prod_reg  <= ghe_pkg::NUM_W'({rd_data_reg, 8'h00} - {8'h00, rd_data_reg});
                    total_reg <= ghe_pkg::TOT_W'(w_eff * h_eff);
                    state_reg <= S_MAP_MUL;
                end
                S_MAP_MUL: state_reg <= S_MAP_DIV;
                S_MAP_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        out_pix_reg   <= div_rsp.quo;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/gray_histogram_equalizer_core.sv
// Channel | Dir | Payload
// in_ch   | in  | cmd[1:0], pixel_value[7:0]
// out_ch  | out | equalised_pixel[7:0]
// cfg     | in  | cfg_we, cfg_index[0:0], cfg_data[12:0]
// Count: read the bin, then write it back. Map: read the bin, scale it, then divide in the 32-step divider.
// Clear and cumulative pass: one bin of the memory per cycle.
// After reset a clearing pass over all bins runs before the first word is taken.
// A waiting result holds off new input words until it is taken.
module gray_histogram_equalizer_core #(
    parameter int NUM_BINS = 256,
    parameter int MAX_DIM  = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ghe_in_if.sink                             in_ch,
    ghe_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [ghe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ghe_pkg::DIM_W-1:0]          cfg_data
);
    logic [ghe_pkg::DIM_W-1:0] width_reg;
    logic [ghe_pkg::DIM_W-1:0] height_reg;
    ghe_pkg::div_req_t         div_req;
    ghe_pkg::div_rsp_t         div_rsp;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ghe_pkg::DIM_W'(1);
            height_reg <= ghe_pkg::DIM_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == ghe_pkg::REG_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == ghe_pkg::REG_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    ghe_ctrl #(.NUM_BINS(NUM_BINS), .MAX_DIM(MAX_DIM)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    ghe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );
endmodule

FILE: sv/ghe_checker.sv
module ghe_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic [1:0] in_cmd,
    input logic out_valid,
    input logic out_ready
);
    // No input word is taken while a result waits
    a_no_in_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");

    // A count word gives no result next cycle
    a_count_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_cmd == ghe_pkg::CMD_COUNT) |=> !out_valid)
        else $error("result after count");

    // Ready drops after an accepted word
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready held after accept");

    // Result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind gray_histogram_equalizer_core ghe_checker u_ghe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);
